>>> rtl/rtfs_pkg.sv
// Shared constants and types for the RGB timed fade sequencer.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package rtfs_pkg;

	localparam int TIME_BITS = 24;
	localparam int LEVEL_BITS = 16;
	localparam int NUM_CH = 3;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
	localparam int PROD_W = TIME_BITS + LEVEL_BITS;
	localparam int NUM_W = PROD_W + 2;
	localparam int STEP_W = $clog2(LEVEL_BITS);

	localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = {LEVEL_BITS{1'b1}};
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	localparam logic [TIME_BITS-1:0] RED_TICKS_RST = TIME_BITS'(3000);
	localparam logic [TIME_BITS-1:0] GREEN_TICKS_RST = TIME_BITS'(2000);
	localparam logic [TIME_BITS-1:0] BLUE_TICKS_RST = TIME_BITS'(1000);
	localparam logic [LEVEL_BITS-1:0] RED_GOAL_RST = LEVEL_BITS'(32768);
	localparam logic [LEVEL_BITS-1:0] GREEN_GOAL_RST = LEVEL_BITS'(0);
	localparam logic [LEVEL_BITS-1:0] BLUE_GOAL_RST = LEVEL_BITS'(0);

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_RED_TICKS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_TICKS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BLUE_TICKS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RED_GOAL = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_GOAL = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BLUE_GOAL = 3'd5;

	typedef enum logic [1:0] {
		PH_OUT = 2'd0,
		PH_HOLD = 2'd1,
		PH_IN = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ARM = 3'd1,
		OP_CHECK = 3'd2,
		OP_MUL = 3'd3,
		OP_DINIT = 3'd4,
		OP_DSTEP = 3'd5,
		OP_STORE = 3'd6,
		OP_FINISH = 3'd7
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [1:0] chan;
	} dp_cmd_t;

	typedef struct packed {
		phase_t mode;
		logic past;
	} dp_status_t;

endpackage

>>> rtl/rtfs_channels.sv
// Valid/ready channel interfaces for the tick request and the level result.
// Depends on rtfs_pkg for the level width.
interface rtfs_in_if import rtfs_pkg::*; ();
	logic valid;
	logic ready;
	logic wake;

	modport source(output valid, output wake, input ready);
	modport sink(input valid, input wake, output ready);
endinterface

interface rtfs_out_if import rtfs_pkg::*; ();
	logic valid;
	logic ready;
	logic [LEVEL_BITS-1:0] red_level;
	logic [LEVEL_BITS-1:0] green_level;
	logic [LEVEL_BITS-1:0] blue_level;
	logic [1:0] phase;

	modport source(output valid, output red_level, output green_level, output blue_level,
		output phase, input ready);
	modport sink(input valid, input red_level, input green_level, input blue_level,
		input phase, output ready);
endinterface

>>> rtl/rtfs_datapath.sv
// Datapath: configuration registers, sequencer state, the shared multiplier,
// the shift-subtract divider and the result register. Depends on rtfs_pkg.
module rtfs_datapath import rtfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [REG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input dp_cmd_t cmd,
	output dp_status_t status,
	output logic [LEVEL_BITS-1:0] red_level,
	output logic [LEVEL_BITS-1:0] green_level,
	output logic [LEVEL_BITS-1:0] blue_level,
	output logic [1:0] phase
);

	logic [TIME_BITS-1:0] ticks_q [NUM_CH];
	logic [LEVEL_BITS-1:0] goal_q [NUM_CH];
	phase_t mode_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TIME_BITS-1:0] rise_q [NUM_CH];
	logic [LEVEL_BITS-1:0] held_q [NUM_CH];

	logic [TIME_BITS-1:0] lim_q;
	logic [LEVEL_BITS-1:0] gsel_q;
	logic [LEVEL_BITS-1:0] diff_q;
	logic past_q;
	logic allp_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0] rem_q;
	logic [PROD_W-1:0] dsh_q;
	logic [LEVEL_BITS-1:0] quo_q;
	logic [LEVEL_BITS-1:0] red_q, green_q, blue_q;
	phase_t phase_q;

	logic [TIME_BITS-1:0] eff [NUM_CH];
	logic [TIME_BITS-1:0] t_max, t_min;
	logic [TIME_BITS:0] rise_sum [NUM_CH];
	logic [TIME_BITS-1:0] lim;
	logic past;
	logic [NUM_W-1:0] dsh_ext;
	logic rem_ge;
	logic [LEVEL_BITS:0] up_sum;
	logic [LEVEL_BITS-1:0] new_lvl;

	// A channel whose goal is full does not fade at all.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			eff[c] = (goal_q[c] == LEVEL_FULL) ? '0 : ticks_q[c];
		end
	end

	// Fade-in times: shortest nonzero fade time plus the lag behind the longest.
	always_comb begin
		t_max = '0;
		t_min = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			if (eff[c] > t_max) begin
				t_max = eff[c];
			end
			if (eff[c] != '0 && (t_min == '0 || eff[c] < t_min)) begin
				t_min = eff[c];
			end
		end
		for (int c = 0; c < NUM_CH; c++) begin
			rise_sum[c] = {1'b0, t_min} + {1'b0, t_max - eff[c]};
		end
	end

	assign lim = (mode_q == PH_OUT) ? eff[cmd.chan] : rise_q[cmd.chan];
	assign past = (elapsed_q >= lim);
	assign status.mode = mode_q;
	assign status.past = past;

	assign dsh_ext = {2'b00, dsh_q};
	assign rem_ge = (rem_q >= dsh_ext);
	assign up_sum = {1'b0, gsel_q} + {1'b0, quo_q};

	always_comb begin
		if (mode_q == PH_OUT) begin
			new_lvl = past_q ? gsel_q : LEVEL_FULL - quo_q;
		end else if (past_q || up_sum[LEVEL_BITS]) begin
			new_lvl = LEVEL_FULL;
		end else begin
			new_lvl = up_sum[LEVEL_BITS-1:0];
		end
	end

	// Configuration and sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q[0] <= RED_TICKS_RST;
			ticks_q[1] <= GREEN_TICKS_RST;
			ticks_q[2] <= BLUE_TICKS_RST;
			goal_q[0] <= RED_GOAL_RST;
			goal_q[1] <= GREEN_GOAL_RST;
			goal_q[2] <= BLUE_GOAL_RST;
			mode_q <= PH_OUT;
			elapsed_q <= '0;
			for (int c = 0; c < NUM_CH; c++) begin
				rise_q[c] <= '0;
				held_q[c] <= LEVEL_FULL;
			end
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx)
					REG_RED_TICKS: ticks_q[0] <= cfg_data[TIME_BITS-1:0];
					REG_GREEN_TICKS: ticks_q[1] <= cfg_data[TIME_BITS-1:0];
					REG_BLUE_TICKS: ticks_q[2] <= cfg_data[TIME_BITS-1:0];
					REG_RED_GOAL: goal_q[0] <= cfg_data[LEVEL_BITS-1:0];
					REG_GREEN_GOAL: goal_q[1] <= cfg_data[LEVEL_BITS-1:0];
					REG_BLUE_GOAL: goal_q[2] <= cfg_data[LEVEL_BITS-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.op == OP_ARM) begin
				for (int c = 0; c < NUM_CH; c++) begin
					rise_q[c] <= rise_sum[c][TIME_BITS] ? TIME_MAX : rise_sum[c][TIME_BITS-1:0];
				end
				elapsed_q <= '0;
				mode_q <= PH_IN;
			end
			if (cmd.op == OP_STORE) begin
				held_q[cmd.chan] <= new_lvl;
			end
			if (cmd.op == OP_FINISH && (mode_q == PH_OUT || mode_q == PH_IN)) begin
				if (allp_q) begin
					mode_q <= (mode_q == PH_OUT) ? PH_HOLD : PH_DONE;
				end else if (elapsed_q != TIME_MAX) begin
					elapsed_q <= elapsed_q + 1'b1;
				end
			end
		end
	end

	// Per-channel arithmetic and the result register.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CHECK: begin
				lim_q <= lim;
				gsel_q <= goal_q[cmd.chan];
				diff_q <= LEVEL_FULL - goal_q[cmd.chan];
				past_q <= past;
				allp_q <= (cmd.chan == 2'd0) ? past : (allp_q & past);
			end
			OP_MUL: begin
				prod_q <= PROD_W'(diff_q * elapsed_q);
			end
			OP_DINIT: begin
				// Round half up: (2*d*t + L) / (2*L), quotient never above d.
				rem_q <= {1'b0, prod_q, 1'b0} + NUM_W'(lim_q);
				dsh_q <= PROD_W'({lim_q, 1'b0}) << (LEVEL_BITS - 1);
				quo_q <= '0;
			end
			OP_DSTEP: begin
				if (rem_ge) begin
					rem_q <= rem_q - dsh_ext;
				end
				quo_q <= {quo_q[LEVEL_BITS-2:0], rem_ge};
				dsh_q <= dsh_q >> 1;
			end
			OP_FINISH: begin
				red_q <= held_q[0];
				green_q <= held_q[1];
				blue_q <= held_q[2];
				phase_q <= mode_q;
			end
			default: begin
			end
		endcase
	end

	assign red_level = red_q;
	assign green_level = green_q;
	assign blue_level = blue_q;
	assign phase = phase_q;

endmodule

>>> rtl/rtfs_controller.sv
// Controller state machine: request handshake, channel sequencing, divider
// step count and result handshake. Depends on rtfs_pkg.
module rtfs_controller import rtfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_wake,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output dp_cmd_t cmd,
	input dp_status_t status
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ARM = 8'b0000_0010,
		ST_CHECK = 8'b0000_0100,
		ST_MUL = 8'b0000_1000,
		ST_DINIT = 8'b0001_0000,
		ST_DSTEP = 8'b0010_0000,
		ST_STORE = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} ctl_state_t;

	ctl_state_t state_q, state_d;
	logic [1:0] chan_q, chan_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;
	logic out_free;
	logic moving;

	assign out_free = !out_valid_q || out_ready;
	assign moving = (status.mode == PH_OUT) || (status.mode == PH_IN);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		chan_d = chan_q;
		cnt_d = cnt_q;
		cmd.chan = chan_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				chan_d = 2'd0;
				if (in_valid) begin
					if (status.mode == PH_HOLD && in_wake) begin
						state_d = ST_ARM;
					end else if (moving) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_ARM: begin
				cmd.op = OP_ARM;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.op = OP_CHECK;
				state_d = status.past ? ST_STORE : ST_MUL;
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.op = OP_DINIT;
				cnt_d = STEP_W'(LEVEL_BITS - 1);
				state_d = ST_DSTEP;
			end
			ST_DSTEP: begin
				cmd.op = OP_DSTEP;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.op = OP_STORE;
				if (chan_q == 2'(NUM_CH - 1)) begin
					state_d = ST_FINISH;
				end else begin
					chan_d = chan_q + 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_FINISH: begin
				// Wait until the result register can take the new levels.
				if (out_free) begin
					cmd.op = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chan_q <= chan_d;
			cnt_q <= cnt_d;
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_finish_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINISH) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still pending");

	a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken before the first finished");

	a_check_while_moving: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (status.mode == PH_OUT || status.mode == PH_IN))
		else $error("channel check outside a fade phase");

	a_channel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK || state_q == ST_STORE) |-> (chan_q != 2'd3))
		else $error("channel index out of range");

	a_divider_ends_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSTEP && cnt_q == '0) |=> (state_q == ST_STORE))
		else $error("divider did not hand over to store");

endmodule

>>> rtl/rgb_timed_fade_sequencer_unit.sv
// Top level of the RGB timed fade sequencer.
// Depends on rtfs_pkg, rtfs_channels, rtfs_controller and rtfs_datapath.
//
// Each request on tick_in is one tick, carrying a wake flag. Each tick gives
// exactly one result on level_out: three 16-bit levels (all ones is full) and
// the phase (fade-out, hold, fade-in, done).
// Configuration: cfg_wen, cfg_idx and cfg_data write one of six registers
// (three fade times, three goal levels); write only while no tick is pending.
// Per tick: a wake in hold arms the fade-in; in fade-out or fade-in each
// channel is checked in turn and stored, a moving channel going first through
// the multiply, the divider set-up and the divider steps; then the result
// register is loaded (in hold or done, straight away). The next tick is taken
// only once the block is back in idle. The pace is set by the single shared
// multiplier and the 16-step shift-subtract divider, used by the channels in turn.
// Reset puts the block in fade-out with all levels full and the registers at
// 3000, 2000, 1000 ticks and goals 32768, 0, 0.
// A stalled receiver keeps the result in the output register; the next tick
// is still accepted and worked on, and waits only to load its result.
module rgb_timed_fade_sequencer_unit import rtfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [REG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data,
	rtfs_in_if.sink tick_in,
	rtfs_out_if.source level_out
);

	dp_cmd_t cmd;
	dp_status_t status;

	rtfs_controller u_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(tick_in.valid),
		.in_wake(tick_in.wake),
		.in_ready(tick_in.ready),
		.out_valid(level_out.valid),
		.out_ready(level_out.ready),
		.cmd(cmd),
		.status(status)
	);

	rtfs_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status),
		.red_level(level_out.red_level),
		.green_level(level_out.green_level),
		.blue_level(level_out.blue_level),
		.phase(level_out.phase)
	);

endmodule

>>> dv/tb.sv
// Self-checking testbench for rgb_timed_fade_sequencer_unit: ticks go in on tick_in, and
// every level result on level_out is checked against a cycle-free predictor of the fades.
// Depends on rtfs_pkg, the rtfs_channels interfaces and the RTL under rtl/.
module tb import rtfs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int QUIET_FROM = 10000;
	localparam int QUIET_TO = 18000;
	localparam int PRESSURE_AT = 4000;
	localparam int PRESSURE_LEN = 600;
	localparam int SHOW_LIMIT = 50;

	localparam int WAKE_LOW = 0;
	localparam int WAKE_HIGH = 1;
	localparam int WAKE_RANDOM = 2;

	localparam int STYLE_FADE = 0;
	localparam int STYLE_FINISH = 1;
	localparam int STYLE_SHORT = 2;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [NUM_CH-1:0][REG_IDX_W-1:0] TICK_REG =
		{REG_BLUE_TICKS, REG_GREEN_TICKS, REG_RED_TICKS};
	localparam logic [NUM_CH-1:0][REG_IDX_W-1:0] GOAL_REG =
		{REG_BLUE_GOAL, REG_GREEN_GOAL, REG_RED_GOAL};
	localparam logic [63:0] FULL64 = 64'(LEVEL_FULL);

	typedef struct packed {
		logic [NUM_CH-1:0][LEVEL_BITS-1:0] lvl;
		phase_t phase;
	} levels_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rtfs_in_if tick_if();
	rtfs_out_if lvl_if();

	rgb_timed_fade_sequencer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.tick_in(tick_if.sink),
		.level_out(lvl_if.source)
	);

	// Predictor state and its copy of the registers.
	phase_t fade_mode;
	logic [TIME_BITS-1:0] fade_elapsed;
	logic [NUM_CH-1:0][TIME_BITS-1:0] rise_len;
	logic [NUM_CH-1:0][LEVEL_BITS-1:0] held;
	logic [NUM_CH-1:0][TIME_BITS-1:0] fade_time;
	logic [NUM_CH-1:0][LEVEL_BITS-1:0] goal;

	logic tick_q[$];
	levels_t expect_q[$];
	int ticks_open;
	logic tick_taken;
	int unsigned cyc;
	int mismatches;
	int results_seen;
	int ticks_sent;
	int phase_count[4];
	int stall_left;
	logic pressure_done;
	string ch_name[NUM_CH] = '{"red", "green", "blue"};

	function automatic logic [63:0] eff_ticks(input int c);
		// A full goal leaves nothing to fade, whatever the programmed time.
		return (goal[c] == LEVEL_FULL) ? 64'd0 : 64'(fade_time[c]);
	endfunction

	function automatic levels_t fade_tick(input logic wake);
		levels_t res;
		logic all_past;
		logic [NUM_CH-1:0][63:0] t_eff;
		logic [63:0] mx, mn, r, lim, g, lvl;
		all_past = 1'b1;
		if (fade_mode == PH_HOLD && wake) begin
			mx = '0;
			mn = '0;
			for (int c = 0; c < NUM_CH; c++) begin
				t_eff[c] = eff_ticks(c);
				if (t_eff[c] > mx)
					mx = t_eff[c];
				if (t_eff[c] != 0 && (mn == 0 || t_eff[c] < mn))
					mn = t_eff[c];
			end
			for (int c = 0; c < NUM_CH; c++) begin
				r = mn + (mx - t_eff[c]);
				rise_len[c] = (r > 64'(TIME_MAX)) ? TIME_MAX : r[TIME_BITS-1:0];
			end
			fade_elapsed = '0;
			fade_mode = PH_IN;
		end
		res.phase = fade_mode;
		if (fade_mode == PH_OUT || fade_mode == PH_IN) begin
			for (int c = 0; c < NUM_CH; c++) begin
				lim = (fade_mode == PH_OUT) ? eff_ticks(c) : 64'(rise_len[c]);
				g = 64'(goal[c]);
				if (64'(fade_elapsed) >= lim) begin
					lvl = (fade_mode == PH_OUT) ? g : FULL64;
				end else begin
					// Linear step, rounded half up.
					lvl = ((FULL64 - g) * 2 * 64'(fade_elapsed) + lim) / (2 * lim);
					if (fade_mode == PH_OUT)
						lvl = FULL64 - lvl;
					else
						lvl = (g + lvl > FULL64) ? FULL64 : g + lvl;
					all_past = 1'b0;
				end
				held[c] = lvl[LEVEL_BITS-1:0];
			end
			if (all_past)
				fade_mode = (fade_mode == PH_OUT) ? PH_HOLD : PH_DONE;
			else if (fade_elapsed != TIME_MAX)
				fade_elapsed = fade_elapsed + 1'b1;
		end
		res.lvl = held;
		return res;
	endfunction

	function automatic logic [LEVEL_BITS-1:0] pick_goal();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return LEVEL_FULL;
			2: return LEVEL_FULL - 1'b1;
			3: return LEVEL_BITS'(1);
			default: return LEVEL_BITS'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		for (int c = 0; c < NUM_CH; c++) begin
			if (idx == TICK_REG[c])
				fade_time[c] = data[TIME_BITS-1:0];
			if (idx == GOAL_REG[c])
				goal[c] = data[LEVEL_BITS-1:0];
		end
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic queue_ticks(input int n, input int wake_kind);
		for (int i = 0; i < n; i++) begin
			case (wake_kind)
				WAKE_LOW: tick_q.push_back(1'b0);
				WAKE_HIGH: tick_q.push_back(1'b1);
				default: tick_q.push_back(1'($urandom_range(0, 1)));
			endcase
			ticks_open++;
			ticks_sent++;
		end
	endtask

	task automatic wait_idle();
		while (ticks_open != 0 || expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Programs all three channels. STYLE_FADE keeps at least one channel fading for
	// the next n ticks, STYLE_FINISH lets the fade-out end within a few ticks, and
	// STYLE_SHORT gives short times so that a fade-in completes quickly.
	task automatic program_channels(input int style, input int n);
		logic [TIME_BITS-1:0] tv;
		logic [LEVEL_BITS-1:0] gv;
		logic [CFG_DATA_W-1:0] gdata;
		int anchor;
		int e;
		anchor = $urandom_range(0, NUM_CH - 1);
		e = int'(fade_elapsed);
		for (int c = 0; c < NUM_CH; c++) begin
			gv = pick_goal();
			tv = TIME_BITS'($urandom);
			case (style)
				STYLE_FADE: begin
					if (c == anchor) begin
						if (gv == LEVEL_FULL)
							gv = LEVEL_FULL - 1'b1;
						if ($urandom_range(0, 3) != 0)
							tv = TIME_BITS'(e + n + $urandom_range(1, 4000));
						else
							tv = TIME_MAX;
					end else begin
						case ($urandom_range(0, 6))
							0: tv = '0;
							1: gv = LEVEL_FULL;
							2: tv = TIME_BITS'($urandom_range(0, e));
							3: tv = TIME_BITS'(e + $urandom_range(1, n));
							4: ;
							5: tv = TIME_MAX;
							default: tv = TIME_BITS'(e + $urandom_range(1, 3));
						endcase
					end
				end
				STYLE_FINISH: begin
					case ($urandom_range(0, 3))
						0: tv = '0;
						1: gv = LEVEL_FULL;
						2: tv = TIME_BITS'($urandom_range(0, e));
						default: tv = TIME_BITS'(e + $urandom_range(0, 25));
					endcase
				end
				default: begin
					case ($urandom_range(0, 5))
						0: tv = '0;
						1: gv = LEVEL_FULL;
						default: tv = TIME_BITS'($urandom_range(1, 80));
					endcase
				end
			endcase
			// The upper data bits of a goal write must be dropped by the block.
			gdata = CFG_DATA_W'($urandom);
			if ($urandom_range(0, 1) == 0)
				gdata = '0;
			gdata[LEVEL_BITS-1:0] = gv;
			write_reg(TICK_REG[c], CFG_DATA_W'(tv));
			write_reg(GOAL_REG[c], gdata);
		end
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_DATA_W'($urandom));
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d ticks and %0d results outstanding.",
				cyc, ticks_open, expect_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Request driver: a new tick is offered only once the previous one was taken.
	always @(negedge clk) begin
		logic calm;
		calm = (cyc >= QUIET_FROM && cyc < QUIET_TO);
		if (!arst_n) begin
			tick_if.valid <= 1'b0;
		end else if (!tick_if.valid || tick_taken) begin
			if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
				tick_if.valid <= 1'b1;
				tick_if.wake <= tick_q.pop_front();
			end else begin
				tick_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold-off while ticks are still queued.
	always @(negedge clk) begin
		logic calm;
		calm = (cyc >= QUIET_FROM && cyc < QUIET_TO);
		if (!pressure_done && cyc >= PRESSURE_AT && ticks_open >= 20) begin
			stall_left = PRESSURE_LEN;
			pressure_done = 1'b1;
		end
		if (!arst_n) begin
			lvl_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			lvl_if.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			lvl_if.ready <= calm || ($urandom_range(0, 99) >= 27);
		end
	end

	// Result checker and predictor update.
	always @(posedge clk) begin
		levels_t got;
		levels_t want;
		if (arst_n && lvl_if.valid && lvl_if.ready) begin
			got.lvl = {lvl_if.blue_level, lvl_if.green_level, lvl_if.red_level};
			got.phase = phase_t'(lvl_if.phase);
			results_seen++;
			phase_count[got.phase]++;
			if (expect_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with no tick waiting: levels %0d %0d %0d phase %0d",
					$time, got.lvl[0], got.lvl[1], got.lvl[2], got.phase);
			end else begin
				want = expect_q.pop_front();
				for (int c = 0; c < NUM_CH; c++) begin
					if (got.lvl[c] !== want.lvl[c]) begin
						mismatches++;
						if (mismatches <= SHOW_LIMIT)
							$display("%0t: %s level expected %0d, got %0d", $time,
								ch_name[c], want.lvl[c], got.lvl[c]);
					end
				end
				if (got.phase !== want.phase) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("%0t: phase expected %0d, got %0d", $time, want.phase,
							got.phase);
				end
			end
		end
		if (arst_n && tick_if.valid && tick_if.ready) begin
			expect_q.push_back(fade_tick(tick_if.wake));
			ticks_open--;
		end
		tick_taken <= tick_if.valid && tick_if.ready;
	end

	initial begin
		int n;
		logic [63:0] longest;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		tick_if.valid = 1'b0;
		tick_if.wake = 1'b0;
		lvl_if.ready = 1'b0;
		tick_taken = 1'b0;
		cyc = 0;
		mismatches = 0;
		results_seen = 0;
		ticks_sent = 0;
		ticks_open = 0;
		stall_left = 0;
		pressure_done = 1'b0;
		fade_mode = PH_OUT;
		fade_elapsed = '0;
		rise_len = '0;
		held = {NUM_CH{LEVEL_FULL}};
		fade_time = {BLUE_TICKS_RST, GREEN_TICKS_RST, RED_TICKS_RST};
		goal = {BLUE_GOAL_RST, GREEN_GOAL_RST, RED_GOAL_RST};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings, with a wake that fade-out must ignore.
		queue_ticks(1, WAKE_LOW);
		queue_ticks(1, WAKE_HIGH);
		wait_idle();

		// Red is already past a one-tick fade, green lands on an exact half step,
		// blue has the longest time there is. Writes to unused indexes change nothing.
		write_reg(REG_RED_TICKS, CFG_DATA_W'(1));
		write_reg(REG_RED_GOAL, '0);
		write_reg(REG_GREEN_TICKS, CFG_DATA_W'(4));
		write_reg(REG_GREEN_GOAL, CFG_DATA_W'(LEVEL_FULL - 1'b1));
		write_reg(REG_BLUE_TICKS, CFG_DATA_W'(TIME_MAX));
		write_reg(REG_BLUE_GOAL, '0);
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		queue_ticks(6, WAKE_RANDOM);
		wait_idle();

		// Zero time on red, full goal on green overriding a huge time, and a goal
		// written with its upper data bits set.
		write_reg(REG_RED_TICKS, '0);
		write_reg(REG_RED_GOAL, CFG_DATA_W'(16'h8001));
		write_reg(REG_GREEN_TICKS, CFG_DATA_W'(TIME_MAX));
		write_reg(REG_GREEN_GOAL, CFG_DATA_W'(LEVEL_FULL));
		write_reg(REG_BLUE_TICKS, CFG_DATA_W'(fade_elapsed + 40));
		write_reg(REG_BLUE_GOAL, {8'hff, 16'h1234});
		queue_ticks(4, WAKE_HIGH);
		queue_ticks(4, WAKE_LOW);
		wait_idle();

		for (int p = 0; p < 9; p++) begin
			n = $urandom_range(60, 120);
			program_channels(STYLE_FADE, n);
			queue_ticks(n, WAKE_RANDOM);
			wait_idle();
		end

		// Let the fade-out run out, then sit in hold.
		program_channels(STYLE_FINISH, 0);
		longest = '0;
		for (int c = 0; c < NUM_CH; c++)
			if (eff_ticks(c) > longest)
				longest = eff_ticks(c);
		n = (longest > 64'(fade_elapsed)) ? int'(longest - 64'(fade_elapsed)) + 1 : 1;
		queue_ticks(n, WAKE_RANDOM);
		queue_ticks(30, WAKE_LOW);
		wait_idle();

		// New times and goals in hold decide the fade-in that the wake starts.
		program_channels(STYLE_SHORT, 0);
		queue_ticks(10, WAKE_LOW);
		queue_ticks(1, WAKE_HIGH);
		wait_idle();
		longest = '0;
		for (int c = 0; c < NUM_CH; c++)
			if (64'(rise_len[c]) > longest)
				longest = 64'(rise_len[c]);
		n = int'(longest);
		queue_ticks(n / 2, WAKE_RANDOM);
		wait_idle();

		// Goals change halfway through the fade-in; the run then ends in done.
		program_channels(STYLE_SHORT, 0);
		queue_ticks(n - n / 2 + 60, WAKE_RANDOM);
		wait_idle();
		repeat (70) @(negedge clk);

		$display("Sent %0d ticks and checked %0d results: %0d fade-out, %0d hold, %0d fade-in,",
			ticks_sent, results_seen, phase_count[PH_OUT], phase_count[PH_HOLD],
			phase_count[PH_IN]);
		$display("%0d done; %0d field mismatches in %0d cycles.", phase_count[PH_DONE],
			mismatches, cyc);
		if (mismatches == 0 && expect_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
